@@ design/frrt_pkg.sv @@
// ----------------------------------------------------------------------------
// Package for the frequency ranked recent table
// Shared constants, storage types and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package frrt_pkg;

   localparam int DEPTH      = 64;
   localparam int KEY_BITS   = 16;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam int RATING_BITS = 16;
   localparam int CAP_BITS   = 7;

   localparam logic [RATING_BITS-1:0] AGE_LIMIT = 16'h8000;

   typedef logic [KEY_BITS-1:0]    key_type;
   typedef logic [ADDR_BITS-1:0]   addr_type;
   typedef logic [COUNT_BITS-1:0]  count_type;
   typedef logic [RATING_BITS-1:0] rating_type;

   typedef struct packed {
      rating_type rating;
      key_type    key;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ_RD,
      ST_READ_CAP,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_MISS,
      ST_EVICT_RD,
      ST_EVICT_CAP,
      ST_HALVE_RD,
      ST_HALVE_WR,
      ST_BUBBLE_RD,
      ST_BUBBLE_CMP,
      ST_DONE
   } state_type;

   localparam logic OP_USE  = 1'b0;
   localparam logic OP_READ = 1'b1;

endpackage

`default_nettype wire

@@ design/frrt_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module frrt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ design/frequency_ranked_recent_table.sv @@
// ----------------------------------------------------------------------------
// Frequency ranked recent table
// Ranked table of keys with use counts, halving aging and bubble reordering.
// ----------------------------------------------------------------------------
// The req channel carries one word per operation: tuser is the operation
// (use of a key or read of a rank), tdata holds the key and the rank. Every
// word yields exactly one rsp word with the hit flag, the new rank, the key
// and count of the entry, the valid flag, the eviction flag and key, and the
// number of entries held. The csr port sets the capacity in use.
// A read fetches the entry at its rank. A use walks one table RAM through a
// single sequencer that reads each entry it visits: the search over the N held
// entries, a halving pass over them when a count passes 0x8000, a miss step
// and an eviction read, and bubbling upward from the entry's rank.
// req_tready is high only while the sequencer is idle.
// Reset empties the table and sets the capacity to 64; no clearing pass is
// needed. A result waits in the rsp output register while the receiver
// stalls, and the next word may be accepted meanwhile; it is held back at
// its end until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module frequency_ranked_recent_table (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata: item_key[15:0], read_rank[21:16], zero padding[23:22]
   input  wire logic [23:0] req_tdata,
   // tuser: operation[0]
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: hit[0], new_rank[6:1], entry_key[22:7], entry_rating[38:23],
   // entry_valid[39], evicted[40], evicted_key[56:41], entries_used[63:57]
   output logic      [63:0] rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [6:0]  csr_wdata
);

   frrt_pkg::state_type  state_ff, state_in;
   frrt_pkg::count_type  fill_ff, fill_in;
   logic [frrt_pkg::CAP_BITS-1:0] cap_ff;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [63:0]          rsp_tdata_ff, rsp_tdata_in;

   frrt_pkg::key_type    key_ff, key_in;
   logic [5:0]           rank_ff, rank_in;
   frrt_pkg::addr_type   scan_ff, scan_in;
   frrt_pkg::addr_type   pos_ff, pos_in;
   frrt_pkg::key_type    cur_key_ff, cur_key_in;
   frrt_pkg::rating_type cur_rating_ff, cur_rating_in;
   logic                 hit_ff, hit_in;
   logic                 evicted_ff, evicted_in;
   frrt_pkg::key_type    evkey_ff, evkey_in;
   logic                 valid_ff, valid_in;

   logic                 ram_we;
   frrt_pkg::addr_type   ram_waddr, ram_raddr;
   frrt_pkg::entry_type  ram_wdata, ram_rdata;
   logic [frrt_pkg::ENTRY_BITS-1:0] ram_rdata_raw;

   frrt_pkg::count_type  cap_eff;
   frrt_pkg::count_type  last_index;
   frrt_pkg::rating_type bumped;

   frrt_ram #(
      .WIDTH (frrt_pkg::ENTRY_BITS),
      .DEPTH (frrt_pkg::DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata_raw)
   );

   assign ram_rdata = frrt_pkg::entry_type'(ram_rdata_raw);

   function automatic frrt_pkg::rating_type halve(frrt_pkg::rating_type r);
      return (r > 16'd1) ? (r >> 1) : 16'd1;
   endfunction

   always_comb begin
      if (cap_ff == 7'd0) begin
         cap_eff = frrt_pkg::count_type'(1);
      end else if (cap_ff > 7'(frrt_pkg::DEPTH)) begin
         cap_eff = frrt_pkg::count_type'(frrt_pkg::DEPTH);
      end else begin
         cap_eff = frrt_pkg::count_type'(cap_ff);
      end
   end

   assign last_index = fill_ff - frrt_pkg::count_type'(1);
   assign bumped     = ram_rdata.rating + 16'd1;

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      key_in        = key_ff;
      rank_in       = rank_ff;
      scan_in       = scan_ff;
      pos_in        = pos_ff;
      cur_key_in    = cur_key_ff;
      cur_rating_in = cur_rating_ff;
      hit_in        = hit_ff;
      evicted_in    = evicted_ff;
      evkey_in      = evkey_ff;
      valid_in      = valid_ff;
      ram_we        = 1'b0;
      ram_waddr     = pos_ff;
      ram_wdata     = '{rating: cur_rating_ff, key: cur_key_ff};
      ram_raddr     = scan_ff;
      req_tready    = 1'b0;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         frrt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               key_in     = frrt_pkg::key_type'(req_tdata[15:0]);
               rank_in    = req_tdata[21:16];
               scan_in    = '0;
               pos_in     = '0;
               hit_in     = 1'b0;
               evicted_in = 1'b0;
               evkey_in   = '0;
               valid_in   = 1'b1;
               if (req_tuser == frrt_pkg::OP_READ) begin
                  state_in = frrt_pkg::ST_READ_RD;
               end else if (fill_ff == '0) begin
                  state_in = frrt_pkg::ST_MISS;
               end else begin
                  state_in = frrt_pkg::ST_SRCH_RD;
               end
            end
         end
         frrt_pkg::ST_READ_RD: begin
            ram_raddr = frrt_pkg::addr_type'(rank_ff);
            state_in  = frrt_pkg::ST_READ_CAP;
         end
         frrt_pkg::ST_READ_CAP: begin
            if (frrt_pkg::count_type'(rank_ff) < fill_ff) begin
               valid_in      = 1'b1;
               cur_key_in    = ram_rdata.key;
               cur_rating_in = ram_rdata.rating;
            end else begin
               valid_in      = 1'b0;
               cur_key_in    = '0;
               cur_rating_in = '0;
            end
            state_in = frrt_pkg::ST_DONE;
         end
         frrt_pkg::ST_SRCH_RD: begin
            ram_raddr = scan_ff;
            state_in  = frrt_pkg::ST_SRCH_CMP;
         end
         frrt_pkg::ST_SRCH_CMP: begin
            if (ram_rdata.key == key_ff) begin
               hit_in        = 1'b1;
               pos_in        = scan_ff;
               cur_key_in    = key_ff;
               cur_rating_in = bumped;
               if (bumped > frrt_pkg::AGE_LIMIT) begin
                  scan_in  = '0;
                  state_in = frrt_pkg::ST_HALVE_RD;
               end else begin
                  state_in = frrt_pkg::ST_BUBBLE_RD;
               end
            end else if (frrt_pkg::count_type'(scan_ff) == last_index) begin
               state_in = frrt_pkg::ST_MISS;
            end else begin
               scan_in  = scan_ff + frrt_pkg::addr_type'(1);
               state_in = frrt_pkg::ST_SRCH_RD;
            end
         end
         frrt_pkg::ST_MISS: begin
            cur_key_in    = key_ff;
            cur_rating_in = 16'd1;
            if (fill_ff >= cap_eff && fill_ff != '0) begin
               state_in = frrt_pkg::ST_EVICT_RD;
            end else begin
               pos_in   = frrt_pkg::addr_type'(fill_ff);
               fill_in  = fill_ff + frrt_pkg::count_type'(1);
               state_in = frrt_pkg::ST_BUBBLE_RD;
            end
         end
         frrt_pkg::ST_EVICT_RD: begin
            ram_raddr = frrt_pkg::addr_type'(last_index);
            state_in  = frrt_pkg::ST_EVICT_CAP;
         end
         frrt_pkg::ST_EVICT_CAP: begin
            evicted_in = 1'b1;
            evkey_in   = ram_rdata.key;
            pos_in     = frrt_pkg::addr_type'(cap_eff - frrt_pkg::count_type'(1));
            fill_in    = cap_eff;
            state_in   = frrt_pkg::ST_BUBBLE_RD;
         end
         frrt_pkg::ST_HALVE_RD: begin
            ram_raddr = scan_ff;
            state_in  = frrt_pkg::ST_HALVE_WR;
         end
         frrt_pkg::ST_HALVE_WR: begin
            ram_we    = 1'b1;
            ram_waddr = scan_ff;
            ram_wdata = '{rating: halve(ram_rdata.rating), key: ram_rdata.key};
            if (frrt_pkg::count_type'(scan_ff) == last_index) begin
               cur_rating_in = halve(cur_rating_ff);
               state_in      = frrt_pkg::ST_BUBBLE_RD;
            end else begin
               scan_in  = scan_ff + frrt_pkg::addr_type'(1);
               state_in = frrt_pkg::ST_HALVE_RD;
            end
         end
         frrt_pkg::ST_BUBBLE_RD: begin
            if (pos_ff == '0) begin
               ram_we   = 1'b1;
               state_in = frrt_pkg::ST_DONE;
            end else begin
               ram_raddr = pos_ff - frrt_pkg::addr_type'(1);
               state_in  = frrt_pkg::ST_BUBBLE_CMP;
            end
         end
         frrt_pkg::ST_BUBBLE_CMP: begin
            ram_we = 1'b1;
            if (ram_rdata.rating <= cur_rating_ff) begin
               ram_wdata = ram_rdata;
               pos_in    = pos_ff - frrt_pkg::addr_type'(1);
               state_in  = frrt_pkg::ST_BUBBLE_RD;
            end else begin
               state_in = frrt_pkg::ST_DONE;
            end
         end
         frrt_pkg::ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {7'(fill_ff), 16'(evkey_ff), evicted_ff, valid_ff,
                                16'(cur_rating_ff), 16'(cur_key_ff), 6'(pos_ff), hit_ff};
               state_in      = frrt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = frrt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= frrt_pkg::ST_IDLE;
         fill_ff       <= '0;
         cap_ff        <= 7'd64;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff  <= rsp_tdata_in;
      key_ff        <= key_in;
      rank_ff       <= rank_in;
      scan_ff       <= scan_in;
      pos_ff        <= pos_in;
      cur_key_ff    <= cur_key_in;
      cur_rating_ff <= cur_rating_in;
      hit_ff        <= hit_in;
      evicted_ff    <= evicted_in;
      evkey_ff      <= evkey_in;
      valid_ff      <= valid_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

`default_nettype wire

@@ design/frrt_checker.sv @@
// ----------------------------------------------------------------------------
// Port checker for the frequency ranked recent table
// Watches the top level's ports and flags handshakes and results that cannot be right.
// ----------------------------------------------------------------------------
`default_nettype none

module frrt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [23:0] req_tdata,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic        csr_we,
   input wire logic [6:0]  csr_wdata
);

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready stayed high after a word was accepted");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp word changed");

   a_fill_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[63:57] <= 7'd64)
      else $error("entries_used above table depth");

   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[39] |-> rsp_tdata[38:7] == 32'd0 && !rsp_tdata[0])
      else $error("invalid entry carries a key, count or hit");

   a_hit_no_evict : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> !rsp_tdata[40] && rsp_tdata[39])
      else $error("a hit reported an eviction or an invalid entry");

endmodule

bind frequency_ranked_recent_table frrt_checker u_frrt_checker (.*);

`default_nettype wire

@@ tb/tb_frequency_ranked_recent_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the frequency ranked recent table
// Drives use and read words through the req stream, predicts every rsp word
// from a behavioural copy of the ranked table and compares them field by
// field. It runs several capacity settings and a long receiver stall.
// ----------------------------------------------------------------------------
module tb_frequency_ranked_recent_table;

   localparam int QUIET_LIMIT = 5000;

   typedef struct {
      logic               op;
      frrt_pkg::key_type  key;
      frrt_pkg::addr_type rank;
   } table_word_type;

   typedef struct {
      logic                 hit;
      frrt_pkg::addr_type   new_rank;
      frrt_pkg::key_type    entry_key;
      frrt_pkg::rating_type entry_rating;
      logic                 entry_valid;
      logic                 evicted;
      frrt_pkg::key_type    evicted_key;
      frrt_pkg::count_type  entries_used;
   } rank_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [6:0]  csr_wdata = '0;

   table_word_type  pending_words[$];
   rank_result_type expected_results[$];

   // Behavioural copy of the table.
   frrt_pkg::key_type table_keys[frrt_pkg::DEPTH];
   int unsigned       table_counts[frrt_pkg::DEPTH];
   int                held_count = 0;
   logic [6:0]        capacity_setting = 7'd64;

   logic req_was_taken = 1'b0;
   bit   sender_idles = 1'b1;
   bit   receiver_idles = 1'b1;
   bit   long_stall_go = 1'b0;
   bit   long_stall_taken = 1'b0;
   int   stall_left = 0;
   int   quiet_cycles = 0;
   int   error_count = 0;
   rank_result_type got_result;
   rank_result_type want_result;

   frequency_ranked_recent_table i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic rank_result_type apply_table_word(logic op, frrt_pkg::key_type key,
                                                        frrt_pkg::addr_type rank);
      rank_result_type   r;
      int                pos;
      int                cap;
      int                j;
      frrt_pkg::key_type moved_key;
      int unsigned       moved_count;
      r = '{default: '0};
      if (op == frrt_pkg::OP_READ) begin
         if (rank < held_count) begin
            r.entry_valid = 1'b1;
            r.entry_key = table_keys[rank];
            r.entry_rating = frrt_pkg::rating_type'(table_counts[rank]);
         end
      end else begin
         pos = held_count;
         for (j = 0; j < held_count && pos == held_count; j++) begin
            if (table_keys[j] == key) pos = j;
         end
         if (pos < held_count) begin
            r.hit = 1'b1;
            table_counts[pos] = table_counts[pos] + 1;
            if (table_counts[pos] > frrt_pkg::AGE_LIMIT) begin
               for (j = 0; j < held_count; j++) begin
                  table_counts[j] = (table_counts[j] > 1) ? table_counts[j] / 2 : 1;
               end
            end
         end else begin
            cap = int'(capacity_setting);
            if (cap < 1) cap = 1;
            if (cap > frrt_pkg::DEPTH) cap = frrt_pkg::DEPTH;
            if (held_count >= cap && held_count > 0) begin
               r.evicted = 1'b1;
               r.evicted_key = table_keys[held_count-1];
               held_count = cap - 1;
            end
            pos = held_count;
            table_keys[pos] = key;
            table_counts[pos] = 1;
            held_count++;
         end
         while (pos > 0 && table_counts[pos-1] <= table_counts[pos]) begin
            moved_key = table_keys[pos];
            moved_count = table_counts[pos];
            table_keys[pos] = table_keys[pos-1];
            table_counts[pos] = table_counts[pos-1];
            table_keys[pos-1] = moved_key;
            table_counts[pos-1] = moved_count;
            pos--;
         end
         r.new_rank = frrt_pkg::addr_type'(pos);
         r.entry_key = table_keys[pos];
         r.entry_rating = frrt_pkg::rating_type'(table_counts[pos]);
         r.entry_valid = 1'b1;
      end
      r.entries_used = frrt_pkg::count_type'(held_count);
      return r;
   endfunction

   task automatic compare_field(input string field, input logic [15:0] want_v,
                                input logic [15:0] got_v);
      if (got_v !== want_v) begin
         error_count++;
         $display("%0t: %s expected %h got %h", $time, field, want_v, got_v);
      end
   endtask

   // Sender: a word stays offered until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_was_taken) begin
         if (pending_words.size() != 0 && !(sender_idles && $urandom_range(99) < 31)) begin
            req_tvalid <= 1'b1;
            req_tuser <= pending_words[0].op;
            req_tdata <= {2'b00, pending_words[0].rank, pending_words[0].key};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver, with one long hold-off on request.
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (long_stall_go && !long_stall_taken) begin
         rsp_tready <= 1'b0;
         stall_left <= 400;
         long_stall_taken <= 1'b1;
      end else begin
         rsp_tready <= !(receiver_idles && $urandom_range(99) < 31);
      end
   end

   always @(posedge clock) begin
      req_was_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got_result.hit = rsp_tdata[0];
            got_result.new_rank = rsp_tdata[6:1];
            got_result.entry_key = rsp_tdata[22:7];
            got_result.entry_rating = rsp_tdata[38:23];
            got_result.entry_valid = rsp_tdata[39];
            got_result.evicted = rsp_tdata[40];
            got_result.evicted_key = rsp_tdata[56:41];
            got_result.entries_used = rsp_tdata[63:57];
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t: result word expected none got %h", $time, rsp_tdata);
            end else begin
               want_result = expected_results.pop_front();
               compare_field("hit", 16'(want_result.hit), 16'(got_result.hit));
               compare_field("new_rank", 16'(want_result.new_rank),
                             16'(got_result.new_rank));
               compare_field("entry_key", want_result.entry_key, got_result.entry_key);
               compare_field("entry_rating", want_result.entry_rating,
                             got_result.entry_rating);
               compare_field("entry_valid", 16'(want_result.entry_valid),
                             16'(got_result.entry_valid));
               compare_field("evicted", 16'(want_result.evicted),
                             16'(got_result.evicted));
               compare_field("evicted_key", want_result.evicted_key,
                             got_result.evicted_key);
               compare_field("entries_used", 16'(want_result.entries_used),
                             16'(got_result.entries_used));
            end
         end
         if (req_tvalid && req_tready) begin
            expected_results.insert(expected_results.size(),
                                    apply_table_word(req_tuser, req_tdata[15:0],
                                                     req_tdata[21:16]));
            void'(pending_words.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_use(input frrt_pkg::key_type key);
      table_word_type w;
      w = '{op: frrt_pkg::OP_USE, key: key, rank: frrt_pkg::addr_type'($urandom)};
      pending_words.insert(pending_words.size(), w);
   endtask

   task automatic queue_read(input frrt_pkg::addr_type rank);
      table_word_type w;
      w = '{op: frrt_pkg::OP_READ, key: frrt_pkg::key_type'($urandom), rank: rank};
      pending_words.insert(pending_words.size(), w);
   endtask

   task automatic queue_random_words(input int count, input int key_span);
      frrt_pkg::key_type salt;
      int                n;
      salt = frrt_pkg::key_type'($urandom);
      for (n = 0; n < count; n++) begin
         if ($urandom_range(99) < 30)
            queue_read(frrt_pkg::addr_type'($urandom_range(frrt_pkg::DEPTH-1)));
         else if ($urandom_range(99) < 80)
            queue_use(frrt_pkg::key_type'($urandom_range(key_span-1)) ^ salt);
         else
            queue_use(frrt_pkg::key_type'($urandom_range(16'hFFFF)));
      end
   endtask

   task automatic drain_table();
      while (pending_words.size() != 0 || expected_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [6:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      capacity_setting = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int n;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty table, edge keys, hits that bubble, reads beyond the fill.
      queue_read(0);
      queue_use(16'h0000);
      queue_use(16'hFFFF);
      queue_use(16'h0000);
      queue_use(16'hA5A5);
      queue_use(16'h5A5A);
      for (n = 0; n < 5; n++) queue_read(frrt_pkg::addr_type'(n));
      queue_read(63);
      queue_use(16'hFFFF);
      queue_use(16'hFFFF);
      queue_read(0);
      queue_read(1);
      drain_table();

      // A capacity of zero acts as one and lies below the fill.
      set_capacity(7'd0);
      queue_use(16'h1234);
      queue_use(16'h1234);
      queue_use(16'h4321);
      queue_read(0);
      queue_read(1);
      drain_table();

      set_capacity(7'd127);
      queue_random_words(120, 96);
      drain_table();

      set_capacity(7'd64);
      long_stall_go = 1'b1;
      queue_random_words(120, 80);
      drain_table();

      set_capacity(7'd3);
      queue_random_words(120, 6);
      drain_table();

      set_capacity(7'd1);
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      queue_random_words(120, 3);
      drain_table();

      set_capacity(7'd17);
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      queue_random_words(120, 24);
      drain_table();

      set_capacity(7'd100);
      queue_random_words(120, 48);
      drain_table();

      set_capacity(7'd4);
      queue_random_words(120, 8);
      drain_table();

      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ files.f @@
design/frrt_pkg.sv
design/frrt_ram.sv
design/frequency_ranked_recent_table.sv
design/frrt_checker.sv
tb/tb_frequency_ranked_recent_table.sv
